/* rtl/steq_pkg.sv */
// Package with the shared types, widths and codes of the sorted timer event queue.
package steq_pkg;

    localparam int QDEPTH   = 16;
    localparam int MAX_RES  = 16;
    localparam int QW       = $clog2(QDEPTH + 1);
    localparam int IW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int SCAN_LIM = (QDEPTH < MAX_RES) ? QDEPTH : MAX_RES;
    localparam int TW       = 32;
    localparam logic [15:0] DEF_WAIT = 16'd250;
    localparam logic [23:0] WAIT_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_EXPIRED = 2'd0,
        K_ADDED   = 2'd1,
        K_FULL    = 2'd2,
        K_QUERY   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_SCAN, S_EMIT, S_ADDEXP, S_RM, S_FIND, S_ACK, S_REJ, S_QRY
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] delay;
        logic [7:0]  task_id;
        logic [15:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_handle;
        logic [7:0]  fired_task_id;
        logic [23:0] wait_res;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [TW-1:0] a;
        logic [TW-1:0] b;
        logic          sub;
    } t_alu_req;

endpackage

/* rtl/steq_cmd_if.sv */
// Handshake channels for commands into and results out of the timer queue.
interface steq_cmd_if import steq_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface steq_res_if import steq_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/steq_alu.sv */
// Shared 32-bit adder and subtractor used by the tick, scan, add, search and query steps of the sequencer.
module steq_alu import steq_pkg::*; (
    input  t_alu_req      i_req,
    output logic [TW-1:0] o_sum
);
    always_comb begin
        o_sum = i_req.a + (i_req.sub ? ~i_req.b : i_req.b) + {{(TW-1){1'b0}}, i_req.sub};
    end
endmodule

/* rtl/sorted_timer_event_queue_unit.sv */
// Top level of the sorted timer event queue: sequencer, entry store and output register.
//  channel   dir  payload                                   handshake
//  i_cmd     in   operation, delay, task_id, handle          valid/ready
//  o_evt     out  kind, fired_handle, fired_task_id, wait_res, last   valid/ready
//  i_cfg_*   in   default_wait                               write enable only
// An item is taken only in the idle state; the block then walks the queue one entry
// per cycle, unless a stalled output holds it, through one shared adder: a tick advances
// time, counts the due head entries and sends each one; an add compacts, searches, inserts.
// A result waits in the output register; a stalled output holds the sequencer.
// Synchronous active-low reset empties the queue and clears time; no clearing pass.
module sorted_timer_event_queue_unit import steq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    steq_cmd_if.sink    i_cmd,
    steq_res_if.source  o_evt,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    t_state        r_state, n_state;
    logic [TW-1:0] r_now, n_now;
    logic [TW-1:0] r_nexp, n_nexp;
    logic [QW-1:0] r_occ, n_occ;
    logic [QW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_wr, n_wr;
    logic [15:0]   r_dw;
    t_cmd          r_cmd;

    logic [TW-1:0] r_exp [QDEPTH];
    logic [7:0]    r_tid [QDEPTH];
    logic [15:0]   r_tok [QDEPTH];

    logic          r_ov;
    t_res          r_res;

    t_alu_req      alu_req;
    logic [TW-1:0] alu_sum;
    logic [TW-1:0] rd_exp;
    logic [7:0]    rd_tid;
    logic          can_put, put_en, shift_en, ins_en, rm_en;
    t_res          put;

    steq_alu u_alu (.i_req(alu_req), .o_sum(alu_sum));

    assign rd_exp  = r_exp[r_cnt[IW-1:0]];
    assign rd_tid  = r_tid[r_cnt[IW-1:0]];
    assign can_put = !r_ov || o_evt.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_evt.valid = r_ov;
    assign o_evt.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_wr    <= '0;
            r_dw    <= DEF_WAIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_wr    <= n_wr;
            if (i_cfg_we) begin
                r_dw <= i_cfg_data;
            end
            if (put_en) begin
                r_ov <= 1'b1;
            end else if (o_evt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nexp <= n_nexp;
        if (put_en) begin
            r_res <= put;
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= i_cmd.data;
        end
        if (rm_en) begin
            r_exp[r_wr[IW-1:0]] <= rd_exp;
            r_tid[r_wr[IW-1:0]] <= rd_tid;
            r_tok[r_wr[IW-1:0]] <= r_tok[r_cnt[IW-1:0]];
        end
        for (int e = 0; e < QDEPTH; e++) begin
            if (shift_en && e < QDEPTH - 1) begin
                r_exp[IW'(e)] <= r_exp[IW'(e + 1)];
                r_tid[IW'(e)] <= r_tid[IW'(e + 1)];
                r_tok[IW'(e)] <= r_tok[IW'(e + 1)];
            end else if (ins_en && QW'(e) == r_cnt) begin
                r_exp[IW'(e)] <= r_nexp;
                r_tid[IW'(e)] <= r_cmd.task_id;
                r_tok[IW'(e)] <= r_cmd.handle;
            end else if (ins_en && QW'(e) > r_cnt && e > 0) begin
                r_exp[IW'(e)] <= r_exp[IW'(e - 1)];
                r_tid[IW'(e)] <= r_tid[IW'(e - 1)];
                r_tok[IW'(e)] <= r_tok[IW'(e - 1)];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_nexp   = r_nexp;
        n_occ    = r_occ;
        n_cnt    = r_cnt;
        n_wr     = r_wr;
        put_en   = 1'b0;
        shift_en = 1'b0;
        ins_en   = 1'b0;
        rm_en    = 1'b0;
        put      = '0;
        alu_req  = '{a: r_now, b: rd_exp, sub: 1'b1};
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_cmd.valid) begin
                    case (i_cmd.data.operation)
                        OP_TICK:  n_state = S_TICK;
                        OP_ADD:   n_state = S_ADDEXP;
                        OP_QUERY: n_state = S_QRY;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                alu_req = '{a: r_now, b: TW'(1), sub: 1'b0};
                n_now   = alu_sum;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Count the due entries at the head before any of them is sent.
                if (r_cnt < r_occ && r_cnt != QW'(SCAN_LIM) && !alu_sum[TW-1]) begin
                    n_cnt = r_cnt + QW'(1);
                end else if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_put) begin
                    put_en   = 1'b1;
                    put      = '{kind: K_EXPIRED, fired_handle: r_tok[0],
                                 fired_task_id: r_tid[0], wait_res: '0,
                                 last: (r_cnt == QW'(1))};
                    shift_en = 1'b1;
                    n_occ    = r_occ - QW'(1);
                    n_cnt    = r_cnt - QW'(1);
                    if (r_cnt == QW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ADDEXP: begin
                alu_req = '{a: r_now, b: TW'(r_cmd.delay), sub: 1'b0};
                n_nexp  = alu_sum;
                n_cnt   = '0;
                n_wr    = '0;
                n_state = (r_cmd.task_id != 8'd0) ? S_RM : S_FIND;
            end
            S_RM: begin
                // Compact the queue in place, dropping entries with the same task id.
                if (r_cnt < r_occ) begin
                    if (rd_tid != r_cmd.task_id) begin
                        rm_en = 1'b1;
                        n_wr  = r_wr + QW'(1);
                    end
                    n_cnt = r_cnt + QW'(1);
                end else begin
                    n_occ   = r_wr;
                    n_cnt   = '0;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                alu_req = '{a: r_nexp, b: rd_exp, sub: 1'b1};
                if (r_occ == QW'(QDEPTH)) begin
                    n_state = S_REJ;
                end else if (r_cnt < r_occ && !alu_sum[TW-1]) begin
                    n_cnt = r_cnt + QW'(1);
                end else begin
                    ins_en  = 1'b1;
                    n_occ   = r_occ + QW'(1);
                    n_state = S_ACK;
                end
            end
            S_ACK, S_REJ: begin
                if (can_put) begin
                    put_en  = 1'b1;
                    put     = '{kind: (r_state == S_ACK) ? K_ADDED : K_FULL,
                                fired_handle: r_cmd.handle, fired_task_id: r_cmd.task_id,
                                wait_res: '0, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                alu_req = '{a: rd_exp, b: r_now, sub: 1'b1};
                put     = '{kind: K_QUERY, fired_handle: '0, fired_task_id: '0,
                            wait_res: '0, last: 1'b1};
                if (r_occ == '0) begin
                    put.wait_res = {8'd0, r_dw};
                end else if (alu_sum == '0 ||
                             (alu_sum[TW-1] && alu_sum[TW-2:0] != '0)) begin
                    // Head is due: now minus expiry is not negative.
                    put.wait_res = '0;
                end else if (alu_sum[TW-1:24] != '0) begin
                    put.wait_res = WAIT_MAX;
                end else begin
                    put.wait_res = alu_sum[23:0];
                end
                if (can_put) begin
                    put_en  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= QW'(QDEPTH))
        else $error("queue occupancy beyond depth");
    a_tick_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TICK |=> r_now == $past(r_now) + TW'(1))
        else $error("tick did not advance time by one");
    a_rm_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RM |-> r_wr <= r_cnt)
        else $error("compaction write ran ahead of read");
    a_emit_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift_en |=> r_occ == $past(r_occ) - QW'(1))
        else $error("fired entry did not leave the queue");
`endif

endmodule
